// ===== rtl/core/htx_pkg.sv =====
// htx_pkg: shared types, phase codes and literal tables for the body text extractor.
// Used by htx_scan and html_body_text_extractor; depends on nothing.

package htx_pkg;

  // Input beat: one document byte plus its end marker
  typedef struct packed {
    logic [7:0] doc_byte;
    logic       doc_last;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       end_of_document;
  } out_item_t;

  // Scanner verdict for one byte: whether it yields a result, and the result
  typedef struct packed {
    logic      has_result;
    out_item_t item;
  } step_res_t;

  // Scanner phases; unused codes behave as PH_DONE
  localparam logic [2:0] PH_BEFORE = 3'd0;
  localparam logic [2:0] PH_TEXT   = 3'd1;
  localparam logic [2:0] PH_TAG    = 3'd2;
  localparam logic [2:0] PH_SCRIPT = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [7:0] CH_LT = 8'h3C; // '<'
  localparam logic [7:0] CH_GT = 8'h3E; // '>'

  localparam logic [2:0] BODY_OPEN_LEN    = 3'd5;
  localparam logic [2:0] BODY_CLOSE_LAST  = 3'd5; // index of final byte of "</body"
  localparam logic [2:0] TAG_PREFIX_SAT   = 3'd7;
  localparam logic [3:0] SCRIPT_CLOSE_LEN = 4'd9;

  // "<body"
  function automatic logic [7:0] body_open_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h3C;
      3'd1:    ch = 8'h62;
      3'd2:    ch = 8'h6F;
      3'd3:    ch = 8'h64;
      3'd4:    ch = 8'h79;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "</body"
  function automatic logic [7:0] body_close_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h3C;
      3'd1:    ch = 8'h2F;
      3'd2:    ch = 8'h62;
      3'd3:    ch = 8'h6F;
      3'd4:    ch = 8'h64;
      3'd5:    ch = 8'h79;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "<script"
  function automatic logic [7:0] script_open_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h3C;
      3'd1:    ch = 8'h73;
      3'd2:    ch = 8'h63;
      3'd3:    ch = 8'h72;
      3'd4:    ch = 8'h69;
      3'd5:    ch = 8'h70;
      3'd6:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "</script>"
  function automatic logic [7:0] script_close_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h3C;
      4'd1:    ch = 8'h2F;
      4'd2:    ch = 8'h73;
      4'd3:    ch = 8'h63;
      4'd4:    ch = 8'h72;
      4'd5:    ch = 8'h69;
      4'd6:    ch = 8'h70;
      4'd7:    ch = 8'h74;
      4'd8:    ch = 8'h3E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/htx_scan.sv =====
// htx_scan: per-byte tag/body/script scanner with its state registers.
// Depends on htx_pkg. State advances only on step_en.

module htx_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  htx_pkg::in_item_t    item,
  output htx_pkg::step_res_t   res
);

  logic [2:0] phase_r, phase_nxt;
  logic [2:0] bom_r,   bom_nxt;   // "<body" match count
  logic [2:0] tpc_r,   tpc_nxt;   // tag prefix count, saturating
  logic       mst_r,   mst_nxt;   // tag may be "<script"
  logic       mbc_r,   mbc_nxt;   // tag may be "</body"
  logic [3:0] scm_r,   scm_nxt;   // "</script>" match count

  logic [7:0] b;
  logic       emit;
  logic       bom_adv;
  logic [2:0] bom_c;
  logic       scm_adv;
  logic [3:0] scm_c;
  logic       mst_c;
  logic       mbc_c;
  logic       script_full;

  assign b = item.doc_byte;

  assign bom_adv = (bom_r < htx_pkg::BODY_OPEN_LEN) && (b == htx_pkg::body_open_char(bom_r));
  assign bom_c   = bom_adv ? bom_r + 3'd1 : {2'b00, (b == htx_pkg::CH_LT)};

  assign scm_adv = (scm_r < htx_pkg::SCRIPT_CLOSE_LEN) &&
                   (b == htx_pkg::script_close_char(scm_r));
  assign scm_c   = scm_adv ? scm_r + 4'd1 : {3'b000, (b == htx_pkg::CH_LT)};

  assign script_full = mst_r && (tpc_r == htx_pkg::TAG_PREFIX_SAT);
  assign mst_c = ((tpc_r != htx_pkg::TAG_PREFIX_SAT) &&
                  (b != htx_pkg::script_open_char(tpc_r))) ? 1'b0 : mst_r;
  assign mbc_c = ((tpc_r < 3'd6) && (b != htx_pkg::body_close_char(tpc_r))) ? 1'b0 : mbc_r;

  always_comb begin
    phase_nxt = phase_r;
    bom_nxt   = bom_r;
    tpc_nxt   = tpc_r;
    mst_nxt   = mst_r;
    mbc_nxt   = mbc_r;
    scm_nxt   = scm_r;
    emit      = 1'b0;

    unique case (phase_r)
      htx_pkg::PH_BEFORE: begin
        bom_nxt = bom_c;
        if (bom_c >= htx_pkg::BODY_OPEN_LEN) begin
          phase_nxt = htx_pkg::PH_TAG;
          tpc_nxt   = htx_pkg::TAG_PREFIX_SAT;
          mst_nxt   = 1'b0;
          mbc_nxt   = 1'b0;
          bom_nxt   = 3'd0;
        end
      end
      htx_pkg::PH_TEXT: begin
        if (b == htx_pkg::CH_LT) begin
          phase_nxt = htx_pkg::PH_TAG;
          tpc_nxt   = 3'd1;
          mst_nxt   = 1'b1;
          mbc_nxt   = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      htx_pkg::PH_TAG: begin
        mst_nxt = mst_c;
        mbc_nxt = mbc_c;
        priority if (mbc_c && (tpc_r == htx_pkg::BODY_CLOSE_LAST)) begin
          phase_nxt = htx_pkg::PH_DONE;
        end else if (b == htx_pkg::CH_GT) begin
          phase_nxt = script_full ? htx_pkg::PH_SCRIPT : htx_pkg::PH_TEXT;
          if (script_full) begin
            scm_nxt = 4'd0;
          end
          mst_nxt = 1'b0;
          mbc_nxt = 1'b0;
          tpc_nxt = 3'd0;
        end else if (tpc_r != htx_pkg::TAG_PREFIX_SAT) begin
          tpc_nxt = tpc_r + 3'd1;
        end
      end
      htx_pkg::PH_SCRIPT: begin
        scm_nxt = scm_c;
        if (scm_c >= htx_pkg::SCRIPT_CLOSE_LEN) begin
          scm_nxt   = 4'd0;
          phase_nxt = htx_pkg::PH_TEXT;
        end
      end
      default: begin
        // done and unused codes: drop everything
      end
    endcase

    if (item.doc_last) begin
      phase_nxt = htx_pkg::PH_BEFORE;
      bom_nxt   = 3'd0;
      tpc_nxt   = 3'd0;
      mst_nxt   = 1'b0;
      mbc_nxt   = 1'b0;
      scm_nxt   = 4'd0;
    end
  end

  assign res.has_result           = emit || item.doc_last;
  assign res.item.text_byte       = emit ? b : 8'h00;
  assign res.item.byte_valid      = emit;
  assign res.item.end_of_document = item.doc_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= htx_pkg::PH_BEFORE;
      bom_r   <= 3'd0;
      tpc_r   <= 3'd0;
      mst_r   <= 1'b0;
      mbc_r   <= 1'b0;
      scm_r   <= 4'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      bom_r   <= bom_nxt;
      tpc_r   <= tpc_nxt;
      mst_r   <= mst_nxt;
      mbc_r   <= mbc_nxt;
      scm_r   <= scm_nxt;
    end
  end

endmodule

// ===== rtl/core/html_body_text_extractor.sv =====
// html_body_text_extractor: top level - input register, scanner, result register.
// Depends on htx_pkg and htx_scan.
//
//  channel | dir | beat contents                        | handshake
//  --------+-----+--------------------------------------+------------------------
//  in_     | in  | doc_byte, doc_last (in_item_t)       | in_valid / in_ready
//  out_    | out | text_byte, byte_valid, end_of_doc    | out_valid / out_ready
//
// One byte per clock sustained while the sink takes results. A beat is held in the
//   input register, is scanned, and its result (if any) lands in the result
//   register, which drives out_valid.
// Throughput is set by the scanner state loop.
// Reset (rst_n low, synchronous) empties both registers and returns the scanner
//   to its before-body phase; no clearing pass.
// Stalls: when the result register is full and out_ready is low the input
//   register holds; in_ready drops only once both are occupied. Bytes that make
//   no result never occupy the result register.

module html_body_text_extractor (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  htx_pkg::in_item_t   in_data,

  output logic                out_valid,
  input  logic                out_ready,
  output htx_pkg::out_item_t  out_data
);

  // input register
  logic               s1_v_r, s1_v_nxt;
  htx_pkg::in_item_t  s1_r;

  // result register
  logic               out_v_r, out_v_nxt;
  htx_pkg::out_item_t out_r;

  logic               fire;     // scan the held byte this cycle
  logic               in_acc;
  htx_pkg::step_res_t res;

  // The held byte can move on once the result slot is free or draining.
  assign fire     = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || fire;
  assign in_acc   = in_valid && in_ready;

  htx_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .item    (s1_r),
    .res     (res)
  );

  assign s1_v_nxt  = in_acc ? 1'b1 : (s1_v_r && !fire);
  assign out_v_nxt = fire ? res.has_result : (out_v_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
    if (fire && res.has_result) begin
      out_r <= res.item;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // A result exists only for a visible byte or for the end of the document.
  a_result_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.byte_valid || out_data.end_of_document))
    else $error("result beat with neither text nor end marker");

  // Dropped bytes carry a zero payload byte.
  a_zero_text: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.byte_valid) |-> (out_data.text_byte == 8'h00))
    else $error("text_byte not zero on a non-text result");

  // Back-pressure only when both stages are full and the sink stalls.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && out_v_r && !out_ready))
    else $error("in_ready low without a full pipeline");

  // A byte that was held while the sink stalled stays held; it is not lost.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ready) |=> (s1_v_r || $past(out_ready)))
    else $error("held byte lost while stalled");

endmodule

// ===== tb/htx_text_checker.sv =====
// htx_text_checker: watches the in_ and out_ channels of the body text extractor, predicts
// every result beat from the accepted input beats and compares field by field.
// Depends on htx_pkg for the beat types, phase codes and character constants.

module htx_text_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  htx_pkg::in_item_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  htx_pkg::out_item_t  out_data,
  output int                  fail_count,
  output int                  outstanding,
  output int                  results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [39:0] LIT_BODY_OPEN   = "<body";
  localparam logic [47:0] LIT_BODY_CLOSE  = "</body";
  localparam logic [55:0] LIT_SCRIPT_OPEN = "<script";
  localparam logic [71:0] LIT_SCRIPT_END  = "</script>";

  // predicted scanner state
  logic [2:0] scan_phase;
  logic [2:0] open_matched;
  logic [2:0] tag_bytes;
  logic       script_candidate;
  logic       body_end_candidate;
  logic [3:0] end_matched;

  htx_pkg::out_item_t expected_text[$];
  htx_pkg::out_item_t want;
  htx_pkg::out_item_t made;
  int                 errors;
  int                 checked;

  // byte idx of a literal held left-aligned in the low len bytes
  function automatic logic [7:0] lit_char(input logic [71:0] lit, input int len, input int idx);
    return lit[8*(len-1-idx) +: 8];
  endfunction

  function automatic void clear_scan_state();
    scan_phase         = htx_pkg::PH_BEFORE;
    open_matched       = '0;
    tag_bytes          = '0;
    script_candidate   = 1'b0;
    body_end_candidate = 1'b0;
    end_matched        = '0;
  endfunction

  // Advance the predicted state by one byte; returns 1 when the byte yields a result.
  function automatic bit scan_doc_byte(input htx_pkg::in_item_t beat,
                                       output htx_pkg::out_item_t res);
    logic [7:0] b;
    logic [2:0] idx;
    bit         emit;
    bit         script_full;
    b    = beat.doc_byte;
    emit = 1'b0;
    case (scan_phase)
      htx_pkg::PH_BEFORE: begin
        if (open_matched < htx_pkg::BODY_OPEN_LEN &&
            b == lit_char(72'(LIT_BODY_OPEN), 5, int'(open_matched))) begin
          open_matched = open_matched + 3'd1;
        end else begin
          open_matched = (b == htx_pkg::CH_LT) ? 3'd1 : 3'd0;
        end
        if (open_matched >= htx_pkg::BODY_OPEN_LEN) begin
          // remainder of the body tag is swallowed as an ordinary tag
          scan_phase         = htx_pkg::PH_TAG;
          tag_bytes          = htx_pkg::TAG_PREFIX_SAT;
          script_candidate   = 1'b0;
          body_end_candidate = 1'b0;
          open_matched       = '0;
        end
      end
      htx_pkg::PH_TEXT: begin
        if (b == htx_pkg::CH_LT) begin
          scan_phase         = htx_pkg::PH_TAG;
          tag_bytes          = 3'd1;
          script_candidate   = 1'b1;
          body_end_candidate = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      htx_pkg::PH_TAG: begin
        idx         = tag_bytes;
        script_full = script_candidate && idx >= htx_pkg::TAG_PREFIX_SAT;
        if (idx < 3'd7 && b != lit_char(72'(LIT_SCRIPT_OPEN), 7, int'(idx)))
          script_candidate = 1'b0;
        if (idx < 3'd6 && b != lit_char(72'(LIT_BODY_CLOSE), 6, int'(idx)))
          body_end_candidate = 1'b0;
        if (body_end_candidate && idx == htx_pkg::BODY_CLOSE_LAST) begin
          scan_phase = htx_pkg::PH_DONE;
        end else if (b == htx_pkg::CH_GT) begin
          if (script_full) begin
            scan_phase  = htx_pkg::PH_SCRIPT;
            end_matched = '0;
          end else begin
            scan_phase = htx_pkg::PH_TEXT;
          end
          script_candidate   = 1'b0;
          body_end_candidate = 1'b0;
          tag_bytes          = '0;
        end else if (idx < htx_pkg::TAG_PREFIX_SAT) begin
          tag_bytes = idx + 3'd1;
        end
      end
      htx_pkg::PH_SCRIPT: begin
        if (end_matched < htx_pkg::SCRIPT_CLOSE_LEN &&
            b == lit_char(LIT_SCRIPT_END, 9, int'(end_matched))) begin
          end_matched = end_matched + 4'd1;
        end else begin
          end_matched = (b == htx_pkg::CH_LT) ? 4'd1 : 4'd0;
        end
        if (end_matched >= htx_pkg::SCRIPT_CLOSE_LEN) begin
          end_matched = '0;
          scan_phase  = htx_pkg::PH_TEXT;
        end
      end
      default: ;
    endcase

    res.text_byte       = emit ? b : 8'h00;
    res.byte_valid      = emit;
    res.end_of_document = beat.doc_last;
    if (beat.doc_last) clear_scan_state();
    return emit || beat.doc_last;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan_state();
      expected_text.delete();
    end else begin
      // results cannot stem from a beat accepted at the same edge, so check first
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %h valid %b end %b",
                   $time, out_data.text_byte, out_data.byte_valid, out_data.end_of_document);
          errors++;
        end else begin
          want = expected_text.pop_front();
          checked++;
          if (out_data.text_byte !== want.text_byte) begin
            $display("%0t: text_byte expected %h actual %h",
                     $time, want.text_byte, out_data.text_byte);
            errors++;
          end
          if (out_data.byte_valid !== want.byte_valid) begin
            $display("%0t: byte_valid expected %b actual %b",
                     $time, want.byte_valid, out_data.byte_valid);
            errors++;
          end
          if (out_data.end_of_document !== want.end_of_document) begin
            $display("%0t: end_of_document expected %b actual %b",
                     $time, want.end_of_document, out_data.end_of_document);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (scan_doc_byte(in_data, made)) expected_text.push_back(made);
      end
    end
    fail_count      <= errors;
    outstanding     <= expected_text.size();
    results_checked <= checked;
  end

endmodule

// ===== tb/html_body_text_extractor_test.sv =====
// html_body_text_extractor_test: stimulus and verdict for the body text extractor.
// Depends on htx_pkg, html_body_text_extractor and htx_text_checker.

module html_body_text_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1000;
  // ~1100 beats, each worst case a sender gap plus a heavy receiver stall;
  // this limit leaves a wide margin
  localparam int CYCLE_LIMIT  = 400000;

  // receiver behaviour, redrawn at random
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  htx_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  htx_pkg::out_item_t out_data;

  int fail_count;
  int outstanding;
  int results_checked;

  int cycles;
  int burst_left;
  int docs_sent;
  int bytes_sent;
  bit steady;

  rx_mode_t   rx_mode;
  int         rx_left;
  logic [7:0] rx_pattern = 8'b1101_0110;

  // document under construction, one byte per entry
  logic [7:0] doc_bytes[$];

  html_body_text_extractor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  htx_text_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped by watchdog after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: free-running, light stalls, heavy stalls, or a rotating fixed pattern.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end else begin
      rx_left--;
    end
    rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= rx_pattern[0];
    endcase
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
  endtask

  // Body text filler: mostly letters, some tag punctuation, some arbitrary bytes.
  function automatic logic [7:0] filler_byte();
    string common = "abcdeopqrstxy ";
    string marks  = "<>/";
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 255));
      1:       return marks[$urandom_range(0, 2)];
      default: return common[$urandom_range(0, common.len() - 1)];
    endcase
  endfunction

  task automatic add_filler(input int n);
    repeat (n) doc_bytes.push_back(filler_byte());
  endtask

  // Sends the built document, last flag on its final byte. The sender works in
  // bursts; between bursts valid may drop for a random gap, unless the document is
  // sent steady. Valid is never lowered and raised within one step.
  task automatic send_document();
    htx_pkg::in_item_t beat;
    int                gap;
    steady = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < doc_bytes.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      beat.doc_byte = doc_bytes[i];
      beat.doc_last = (i == doc_bytes.size() - 1);
      in_valid <= 1'b1;
      in_data  <= beat;
      do @(posedge clk); while (!in_ready);
      bytes_sent++;
    end
    docs_sent++;
    doc_bytes.delete();
  endtask

  initial begin : stimulus
    int pieces;
    int cut;
    int directed_bytes;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed documents ---
    // no body at all: only the end marker comes out
    add_text("q");
    send_document();
    // body tag that never closes
    add_text("<body");
    send_document();
    // extreme byte values, nested '<' inside a tag, then the body close drops the tail
    add_text("<body>");
    doc_bytes.push_back(8'h00);
    add_text("<a<>");
    doc_bytes.push_back(8'hFF);
    add_text("</body>k");
    send_document();
    // longer script name still counts as a script; text resumes after its end tag
    add_text("<body><scripts>x</script>y");
    send_document();
    // script never closed
    add_text("<body><script>a");
    send_document();
    directed_bytes = bytes_sent;

    // --- random documents: mostly well-formed, with near misses and truncation ---
    while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) add_text("<html><head><title>t</title></head>");
      add_filler($urandom_range(0, 4));
      case ($urandom_range(0, 9))
        0:       add_text("<bodx>");
        1:       add_text("<BODY>");
        2:       add_text("<bod<body class=x>");
        3:       add_text("<body");
        default: add_text("<body>");
      endcase
      pieces = $urandom_range(2, 8);
      repeat (pieces) begin
        case ($urandom_range(0, 11))
          0, 1, 2, 3: add_filler($urandom_range(1, 10));
          4:          add_text("<p>");
          5:          add_text("<a href=x<y>");
          6:          add_text("</bodx>");
          7:          add_text("<scrip>z");
          8, 9: begin
            case ($urandom_range(0, 2))
              0:       add_text("<script>");
              1:       add_text("<scripts>");
              default: add_text("<script src=y>");
            endcase
            add_filler($urandom_range(0, 6));
            // partial end tags must not close the script
            if ($urandom_range(0, 1) == 1) add_text("</scrip<");
            add_filler($urandom_range(0, 4));
            if ($urandom_range(0, 5) != 0) add_text("</script>");
          end
          10:         add_text("<br/>");
          default: begin
            add_text("</body>");
            add_filler($urandom_range(0, 4));
          end
        endcase
      end
      // occasionally chop the document so it ends mid-tag or mid-script
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, doc_bytes.size());
        while (doc_bytes.size() > cut) doc_bytes.delete(doc_bytes.size() - 1);
      end
      send_document();
    end
    in_valid <= 1'b0;

    // drain: wait for every predicted result, then wait on for stray beats
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);

    $display("Covered %0d documents, %0d bytes, directed cases then random ones,", docs_sent,
             bytes_sent);
    $display("under sender gaps and receiver stalls; %0d result beats compared.",
             results_checked);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
